### design/rtg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rtg_pkg;
    localparam int SUM_W      = 32;
    localparam int OUT_W      = 16;
    localparam int DEN_W      = SUM_W + 1;
    localparam int DIV_STEPS  = 2 * OUT_W;
    localparam int SQRT_STEPS = OUT_W;
    localparam int SQ_REM_W   = OUT_W + 2;
    localparam int LATENCY    = 1 + DIV_STEPS + SQRT_STEPS;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [OUT_W-1:0] pix_t;
endpackage
`default_nettype wire

### design/rtg_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rtg_in_if;
    import rtg_pkg::*;
    logic valid;
    logic ready;
    sum_t red_sum;
    sum_t green_sum;
    sum_t blue_sum;
    sum_t weight_sum;
    logic frame_end;
    modport source (output valid, red_sum, green_sum, blue_sum, weight_sum, frame_end,
                    input ready);
    modport sink (input valid, red_sum, green_sum, blue_sum, weight_sum, frame_end,
                  output ready);
endinterface
`default_nettype wire

### design/rtg_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface rtg_out_if;
    import rtg_pkg::*;
    logic valid;
    logic ready;
    pix_t red_out;
    pix_t green_out;
    pix_t blue_out;
    logic no_weight;
    logic frame_end_out;
    modport source (output valid, red_out, green_out, blue_out, no_weight, frame_end_out,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, no_weight, frame_end_out,
                  output ready);
endinterface
`default_nettype wire

### design/rtg_chan.sv
`timescale 1ns / 1ps
`default_nettype none
module rtg_chan (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire rtg_pkg::sum_t s,
    input  wire rtg_pkg::sum_t w,
    output rtg_pkg::pix_t     res
);
    import rtg_pkg::*;

    // divider stages: remainder, divisor, quotient
    logic [DEN_W-1:0]     rem_reg [0:DIV_STEPS-1];
    logic [DEN_W-1:0]     den_reg [0:DIV_STEPS-1];
    logic [DIV_STEPS-1:0] quo_reg [0:DIV_STEPS];

    // square root stages: radicand left, partial remainder, root
    logic [DIV_STEPS-1:0] rad_reg  [1:SQRT_STEPS-1];
    logic [SQ_REM_W-1:0]  srem_reg [1:SQRT_STEPS-1];
    logic [OUT_W-1:0]     root_reg [1:SQRT_STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, s};
            den_reg[0] <= {1'b0, s} + {1'b0, w};
            quo_reg[0] <= '0;
        end
    end

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_div
            logic [DEN_W:0]   sh;
            logic             ge;
            logic [DEN_W-1:0] rem_next;
            assign sh = {rem_reg[k], 1'b0};
            assign ge = sh >= {1'b0, den_reg[k]};
            assign rem_next = ge ? DEN_W'(sh - {1'b0, den_reg[k]}) : sh[DEN_W-1:0];
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    quo_reg[k+1] <= {quo_reg[k][DIV_STEPS-2:0], ge};
                end
            end
            if (k < DIV_STEPS - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rem_reg[k+1] <= rem_next;
                        den_reg[k+1] <= den_reg[k];
                    end
                end
            end
        end
    endgenerate

    generate
        for (k = 0; k < SQRT_STEPS; k++)
        begin : g_sqrt
            logic [DIV_STEPS-1:0] rad_in;
            logic [SQ_REM_W-1:0]  srem_in;
            logic [OUT_W-1:0]     root_in;
            logic [SQ_REM_W+1:0]  cur;
            logic [SQ_REM_W+1:0]  trial;
            logic                 ge;
            if (k == 0)
            begin : g_first
                assign rad_in  = quo_reg[DIV_STEPS];
                assign srem_in = '0;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rad_in  = rad_reg[k];
                assign srem_in = srem_reg[k];
                assign root_in = root_reg[k];
            end
            assign cur   = {srem_in, rad_in[DIV_STEPS-1 -: 2]};
            assign trial = {2'b00, root_in, 2'b01};
            assign ge    = cur >= trial;
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    root_reg[k+1] <= {root_in[OUT_W-2:0], ge};
                end
            end
            if (k < SQRT_STEPS - 1)
            begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rad_reg[k+1]  <= {rad_in[DIV_STEPS-3:0], 2'b00};
                        srem_reg[k+1] <= ge ? SQ_REM_W'(cur - trial) : cur[SQ_REM_W-1:0];
                    end
                end
            end
        end
    endgenerate

    assign res = root_reg[SQRT_STEPS];
endmodule
`default_nettype wire

### design/reinhard_tonemap_gamma.sv
// Reinhard tone mapping with gamma 2 for accumulated pixels.
// pix_in carries three channel radiance sums and the weight sum (Q16.16)
// plus a frame-end mark; pix_out returns sqrt(s / (s + w)) per channel
// as Q0.16, a no_weight flag and the frame-end mark.
// A zero weight sum gives zero colours and raises no_weight.
// Each channel runs a 32-stage restoring divider (one quotient bit per
// stage) followed by a 16-stage square root (one root bit per stage).
// One pixel may be transferred every cycle while pix_out is not stalled.
// The whole pipeline advances together; when pix_out is stalled with a
// result waiting, every stage holds and pix_in.ready drops, so nothing is
// lost or repeated. Bubbles stay in place while the output waits.
// Reset clears all stage valid bits; pixel data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module reinhard_tonemap_gamma (
    input  wire logic clk,
    input  wire logic rst_n,
    rtg_in_if.sink    pix_in,
    rtg_out_if.source pix_out
);
    import rtg_pkg::*;

    logic               en;
    logic [LATENCY-1:0] vld_reg;
    logic [LATENCY-1:0] nw_reg;
    logic [LATENCY-1:0] fe_reg;
    logic               wz;
    sum_t               w_eff;
    sum_t               r_eff;
    sum_t               g_eff;
    sum_t               b_eff;

    assign en = !vld_reg[LATENCY-1] || pix_out.ready;
    assign pix_in.ready = en;

    // zero weight: feed 0 / 1 so the channel result is zero
    assign wz    = pix_in.weight_sum == '0;
    assign w_eff = wz ? SUM_W'(1) : pix_in.weight_sum;
    assign r_eff = wz ? '0 : pix_in.red_sum;
    assign g_eff = wz ? '0 : pix_in.green_sum;
    assign b_eff = wz ? '0 : pix_in.blue_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], pix_in.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nw_reg <= {nw_reg[LATENCY-2:0], wz};
            fe_reg <= {fe_reg[LATENCY-2:0], pix_in.frame_end};
        end
    end

    rtg_chan u_red   (.clk(clk), .en(en), .s(r_eff), .w(w_eff), .res(pix_out.red_out));
    rtg_chan u_green (.clk(clk), .en(en), .s(g_eff), .w(w_eff), .res(pix_out.green_out));
    rtg_chan u_blue  (.clk(clk), .en(en), .s(b_eff), .w(w_eff), .res(pix_out.blue_out));

    assign pix_out.valid         = vld_reg[LATENCY-1];
    assign pix_out.no_weight     = nw_reg[LATENCY-1];
    assign pix_out.frame_end_out = fe_reg[LATENCY-1];

`ifndef SYNTH
    a_zero_colours: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && pix_out.no_weight |->
            pix_out.red_out == '0 && pix_out.green_out == '0 && pix_out.blue_out == '0)
        else $error("colours not zero on zero weight");

    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.ready == (!pix_out.valid || pix_out.ready))
        else $error("input ready does not follow output stall");

    a_valid_flow: assert property (@(posedge clk) disable iff (!rst_n)
        en && !vld_reg[LATENCY-2] |=> !pix_out.valid)
        else $error("output valid without an item behind it");
`endif
endmodule
`default_nettype wire
